// ===== rtl/blps_pkg.sv =====
// ----------------------------------------------------------------------------
// blps_pkg
// Shared types and constants of the line pixel stepper: item modes and the
// default geometry of coordinates, colors and the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

package blps_pkg;

	// default coordinate width, also the default value of the top parameter
	localparam int COORD_WIDTH_DFLT = 10;

	// rgb565 color width
	localparam int COLOR_WIDTH = 16;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// item mode codes
	typedef enum logic [0:0] {
		MODE_START   = 1'b0,
		MODE_ADVANCE = 1'b1
	} mode_t;

endpackage

`default_nettype wire

// ===== rtl/bresenham_line_pixel_stepper_core.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_pixel_stepper_core
// Integer Bresenham line rasterizer for all octants, at most one pixel per beat.
// ----------------------------------------------------------------------------
// A start beat (mode 0) loads both endpoints and a color and returns the first
// endpoint; each advance beat (mode 1) returns the next pixel of the line, and
// the pixel equal to the end point comes with last set, after which advance
// beats return nothing until the next start. A start always drops any line in
// progress. While a line runs and neither side stalls, the block takes one
// input beat and returns one pixel per clock: the stepping loop in the back
// end does one step per cycle, and a two-entry command queue plus the output
// register keep input and output running while the other side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_pixel_stepper_core #(
	parameter int COORD_WIDTH = blps_pkg::COORD_WIDTH_DFLT
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             mode,
	input  wire logic [COORD_WIDTH-1:0]           start_x,
	input  wire logic [COORD_WIDTH-1:0]           start_y,
	input  wire logic [COORD_WIDTH-1:0]           end_x,
	input  wire logic [COORD_WIDTH-1:0]           end_y,
	input  wire logic [blps_pkg::COLOR_WIDTH-1:0] color,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [COORD_WIDTH-1:0]                pixel_x,
	output logic [COORD_WIDTH-1:0]                pixel_y,
	output logic [blps_pkg::COLOR_WIDTH-1:0]      pixel_color,
	output logic                                  last
);

	localparam int CMD_WIDTH = 1 + 6 * COORD_WIDTH + 2 + blps_pkg::COLOR_WIDTH;

	logic                 push;
	logic [CMD_WIDTH-1:0] push_data;
	logic                 queue_full;
	logic                 queue_not_empty;
	logic [CMD_WIDTH-1:0] pop_data;
	logic                 pop;

	// front end: set up and queue
	blps_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.CMD_WIDTH   (CMD_WIDTH)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.color      (color),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	// command queue between the two halves
	blps_queue #(
		.DATA_WIDTH (CMD_WIDTH),
		.DEPTH      (blps_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.pop_data  (pop_data)
	);

	// back end: stepping and output register
	blps_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.CMD_WIDTH   (CMD_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_avail   (queue_not_empty),
		.cmd_data    (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last        (last)
	);

endmodule

`default_nettype wire

// ===== rtl/blps_front.sv =====
// ----------------------------------------------------------------------------
// blps_front
// Front end: takes input beats, works out the absolute deltas and step
// directions for every beat and queues them together with the mode.
// ----------------------------------------------------------------------------
`default_nettype none

module blps_front #(
	parameter int COORD_WIDTH = blps_pkg::COORD_WIDTH_DFLT,
	parameter int CMD_WIDTH   = 1 + 6 * COORD_WIDTH + 2 + blps_pkg::COLOR_WIDTH
) (
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         mode,
	input  wire logic [COORD_WIDTH-1:0]       start_x,
	input  wire logic [COORD_WIDTH-1:0]       start_y,
	input  wire logic [COORD_WIDTH-1:0]       end_x,
	input  wire logic [COORD_WIDTH-1:0]       end_y,
	input  wire logic [blps_pkg::COLOR_WIDTH-1:0] color,
	input  wire logic                         queue_full,
	output logic                              push,
	output logic [CMD_WIDTH-1:0]              push_data
);

	logic [COORD_WIDTH-1:0] delta_x;
	logic [COORD_WIDTH-1:0] delta_y;
	logic                   neg_x;
	logic                   neg_y;

	// accept whenever the queue has room
	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	// absolute deltas and step directions
	always_comb begin
		neg_x   = !(start_x < end_x);
		neg_y   = !(start_y < end_y);
		delta_x = neg_x ? (start_x - end_x) : (end_x - start_x);
		delta_y = neg_y ? (start_y - end_y) : (end_y - start_y);
	end

	// command word: mode, endpoints, deltas, directions, color
	assign push_data = {mode, start_x, start_y, end_x, end_y,
		delta_x, delta_y, neg_x, neg_y, color};

endmodule

`default_nettype wire

// ===== rtl/blps_queue.sv =====
// ----------------------------------------------------------------------------
// blps_queue
// Short register queue that decouples the front end from the stepping back
// end, so either side can stall without holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module blps_queue #(
	parameter int DATA_WIDTH = 8,
	parameter int DEPTH      = blps_pkg::QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire logic [DATA_WIDTH-1:0] push_data,
	input  wire logic                  pop,
	output logic                       full,
	output logic                       not_empty,
	output logic [DATA_WIDTH-1:0]      pop_data
);

	localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_WIDTH = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_WIDTH-1:0]  wr_ptr_q;
	logic [PTR_WIDTH-1:0]  rd_ptr_q;
	logic [CNT_WIDTH-1:0]  count_q;

	assign full      = (count_q == CNT_WIDTH'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/blps_back.sv =====
// ----------------------------------------------------------------------------
// blps_back
// Back end: holds the line state, runs one Bresenham step per advance and
// presents each pixel in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blps_back #(
	parameter int COORD_WIDTH = blps_pkg::COORD_WIDTH_DFLT,
	parameter int CMD_WIDTH   = 1 + 6 * COORD_WIDTH + 2 + blps_pkg::COLOR_WIDTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cmd_avail,
	input  wire logic [CMD_WIDTH-1:0]             cmd_data,
	output logic                                  pop,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [COORD_WIDTH-1:0]                pixel_x,
	output logic [COORD_WIDTH-1:0]                pixel_y,
	output logic [blps_pkg::COLOR_WIDTH-1:0]      pixel_color,
	output logic                                  last
);

	localparam int EW = COORD_WIDTH + 2;

	// command fields
	logic                             c_mode_raw;
	blps_pkg::mode_t                  c_mode;
	logic [COORD_WIDTH-1:0]           c_sx, c_sy, c_ex, c_ey, c_dx, c_dy;
	logic                             c_negx, c_negy;
	logic [blps_pkg::COLOR_WIDTH-1:0] c_color;

	// line state
	logic [COORD_WIDTH-1:0]           cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [COORD_WIDTH-1:0]           dx_q, dy_q;
	logic                             negx_q, negy_q;
	logic signed [EW-1:0]             err_q;
	logic [blps_pkg::COLOR_WIDTH-1:0] color_q;
	logic                             busy_q;
	logic                             out_valid_q;

	// step arithmetic
	logic signed [EW:0]               e2, dx_s, ndy_s, err_ext, err_step;
	logic                             move_x, move_y;
	logic [COORD_WIDTH-1:0]           step_x, step_y;

	// next values
	logic [COORD_WIDTH-1:0]           nx_x, nx_y, nx_tx, nx_ty;
	logic                             emit, at_end;

	assign {c_mode_raw, c_sx, c_sy, c_ex, c_ey, c_dx, c_dy, c_negx, c_negy,
		c_color} = cmd_data;
	assign c_mode = blps_pkg::mode_t'(c_mode_raw);

	// take a command when the output register is free or draining
	assign pop = cmd_avail && (!out_valid_q || !out_stall);

	// one bresenham step on registered state
	always_comb begin
		err_ext  = {err_q[EW-1], err_q};
		e2       = {err_q, 1'b0};
		dx_s     = {2'b00, 1'b0, dx_q};
		ndy_s    = -$signed({2'b00, 1'b0, dy_q});
		move_x   = (e2 > ndy_s);
		move_y   = (e2 < dx_s);
		err_step = err_ext + (move_x ? ndy_s : '0) + (move_y ? dx_s : '0);
		step_x   = negx_q ? (cur_x_q - COORD_WIDTH'(1)) : (cur_x_q + COORD_WIDTH'(1));
		step_y   = negy_q ? (cur_y_q - COORD_WIDTH'(1)) : (cur_y_q + COORD_WIDTH'(1));
	end

	// select start or step and decide whether a pixel goes out
	always_comb begin
		unique case (c_mode)
			blps_pkg::MODE_START: begin
				nx_x  = c_sx;
				nx_y  = c_sy;
				nx_tx = c_ex;
				nx_ty = c_ey;
				emit  = 1'b1;
			end
			blps_pkg::MODE_ADVANCE: begin
				nx_x  = move_x ? step_x : cur_x_q;
				nx_y  = move_y ? step_y : cur_y_q;
				nx_tx = tgt_x_q;
				nx_ty = tgt_y_q;
				emit  = busy_q;
			end
			default: begin
				nx_x  = cur_x_q;
				nx_y  = cur_y_q;
				nx_tx = tgt_x_q;
				nx_ty = tgt_y_q;
				emit  = 1'b0;
			end
		endcase
		at_end = (nx_x == nx_tx) && (nx_y == nx_ty);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			tgt_x_q     <= '0;
			tgt_y_q     <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			negx_q      <= 1'b0;
			negy_q      <= 1'b0;
			err_q       <= '0;
			color_q     <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
				busy_q      <= !at_end;
				cur_x_q     <= nx_x;
				cur_y_q     <= nx_y;
				if (c_mode == blps_pkg::MODE_START) begin
					tgt_x_q <= c_ex;
					tgt_y_q <= c_ey;
					dx_q    <= c_dx;
					dy_q    <= c_dy;
					negx_q  <= c_negx;
					negy_q  <= c_negy;
					err_q   <= $signed({2'b00, c_dx}) - $signed({2'b00, c_dy});
					color_q <= c_color;
				end else begin
					err_q   <= err_step[EW-1:0];
				end
			end
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			pixel_x     <= nx_x;
			pixel_y     <= nx_y;
			pixel_color <= (c_mode == blps_pkg::MODE_START) ? c_color : color_q;
			last        <= at_end;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
